[design/rkc3_pkg.sv]
// Shared types and constants of the 3x3 RGB convolution block.
`default_nettype none
package rkc3_pkg;
	localparam int CH_W         = 8;
	localparam int RGB_W        = 3 * CH_W;
	localparam int PIX_W        = RGB_W + 1;
	localparam int SEL_BIT      = RGB_W;
	localparam int POS_W        = 11;
	localparam int CFG_REG_W    = 12;
	localparam int HEIGHT_LIMIT = 2048;
	localparam int CH_MAX       = 255;
	localparam int WIN_N        = 9;
	localparam int REG_IDX_W    = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_KERNEL_TOP   = 3'd2,
		REG_KERNEL_MID   = 3'd3,
		REG_KERNEL_BOT   = 3'd4
	} reg_idx_t;

	// One filter job: window in raster order (row*3+col), RGB only.
	typedef struct packed {
		logic [WIN_N-1:0][RGB_W-1:0] pixels;
		logic [POS_W-1:0]            column;
		logic [POS_W-1:0]            row;
		logic                        last;
	} rkc3_job_t;
endpackage
`default_nettype wire

[design/rkc3_stream_if.sv]
// Pixel and result stream interfaces.
`default_nettype none
interface rkc3_pix_if import rkc3_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] pixel_red;
	logic [CH_W-1:0] pixel_green;
	logic [CH_W-1:0] pixel_blue;
	logic            selected;
	logic            frame_start;

	modport source (output valid, pixel_red, pixel_green, pixel_blue, selected, frame_start,
		input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, selected, frame_start,
		output ready);
endinterface

interface rkc3_res_if import rkc3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic [POS_W-1:0] out_column;
	logic [POS_W-1:0] out_row;
	logic             frame_last;

	modport source (output valid, out_red, out_green, out_blue, out_column, out_row, frame_last,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_column, out_row, frame_last,
		output ready);
endinterface
`default_nettype wire

[design/rkc3_front.sv]
// Front end: position counters, line stores, 3x3 window, job issue.
`default_nettype none
module rkc3_front import rkc3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rkc3_pix_if.sink                  pix,
	input  wire logic [CFG_REG_W-1:0] line_width,
	input  wire logic [CFG_REG_W-1:0] frame_height,
	output rkc3_job_t                 job,
	output logic                      job_valid,
	input  wire logic                 job_ready
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int HW = POS_W + 1;

	typedef enum logic {S_IDLE, S_RD} state_t;
	state_t state_q;

	logic [CW-1:0]    col_q;
	logic [POS_W-1:0] row_q;
	logic [CW-1:0]    x_q;
	logic [POS_W-1:0] y_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] up_rd_q, mid_rd_q;
	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] win_d [3][3];

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] mid_mem   [MAX_WIDTH];

	logic [WW-1:0]    w;
	logic [HW-1:0]    h;
	logic [WW-1:0]    c_in;
	logic [HW-1:0]    r_in;
	logic [CW-1:0]    x_in;
	logic [POS_W-1:0] y_in;
	logic [WW-1:0]    c_nx;
	logic [HW-1:0]    r_nx;
	logic             accept;

	// effective sizes
	always_comb begin
		if (line_width < CFG_REG_W'(3))
			w = WW'(3);
		else if (int'(line_width) > MAX_WIDTH)
			w = WW'(MAX_WIDTH);
		else
			w = WW'(line_width);
		if (frame_height < CFG_REG_W'(3))
			h = HW'(3);
		else if (frame_height > CFG_REG_W'(HEIGHT_LIMIT))
			h = HW'(HEIGHT_LIMIT);
		else
			h = HW'(frame_height);
	end

	// position of the incoming pixel
	always_comb begin
		c_in = pix.frame_start ? '0 : {1'b0, col_q};
		r_in = pix.frame_start ? '0 : {1'b0, row_q};
		if (c_in >= w) begin
			c_in = '0;
			r_in = r_in + HW'(1);
		end
		if (r_in >= h)
			r_in = '0;
		x_in = c_in[CW-1:0];
		y_in = r_in[POS_W-1:0];
	end

	// position after this pixel
	always_comb begin
		c_nx = {1'b0, x_q} + WW'(1);
		r_nx = {1'b0, y_q};
		if (c_nx >= w) begin
			c_nx = '0;
			r_nx = r_nx + HW'(1);
			if (r_nx >= h)
				r_nx = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_d[i][0] = win_q[i][1];
			win_d[i][1] = win_q[i][2];
		end
		win_d[0][2] = up_rd_q;
		win_d[1][2] = mid_rd_q;
		win_d[2][2] = pix_q;
	end

	assign accept    = pix.valid && pix.ready;
	assign pix.ready = (state_q == S_IDLE) && job_ready;
	assign job_valid = (state_q == S_RD) && (x_q >= CW'(2)) && (y_q >= POS_W'(2))
		&& win_d[1][1][SEL_BIT];

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				job.pixels[i*3+j] = win_d[i][j][RGB_W-1:0];
		job.column = POS_W'(int'(x_q) - 2);
		job.row    = y_q - POS_W'(2);
		job.last   = ({1'b0, x_q} == w - WW'(1)) && ({1'b0, y_q} == h - HW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win_q[i][j] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_RD;
				end
				S_RD: begin
					win_q   <= win_d;
					col_q   <= c_nx[CW-1:0];
					row_q   <= r_nx[POS_W-1:0];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and line stores
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= x_in;
			y_q      <= y_in;
			pix_q    <= {pix.selected, pix.pixel_red, pix.pixel_green, pix.pixel_blue};
			up_rd_q  <= upper_mem[x_in];
			mid_rd_q <= mid_mem[x_in];
		end
		if (state_q == S_RD) begin
			upper_mem[x_q] <= mid_rd_q;
			mid_mem[x_q]   <= pix_q;
		end
	end
endmodule
`default_nettype wire

[design/rkc3_queue.sv]
// Two-entry job queue between front and back end.
`default_nettype none
module rkc3_queue import rkc3_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  rkc3_job_t push_job,
	output logic      not_full,
	input  wire logic pop,
	output rkc3_job_t pop_job,
	output logic      not_empty
);
	rkc3_job_t  slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_job   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_job;
	end
endmodule
`default_nettype wire

[design/rkc3_back.sv]
// Back end: multiply-accumulate, normalizing divide, clamp, result register.
`default_nettype none
module rkc3_back import rkc3_pkg::*; #(
	parameter int COEF_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  rkc3_job_t                   job,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire logic [3*COEF_BITS-1:0] kernel_top_row,
	input  wire logic [3*COEF_BITS-1:0] kernel_middle_row,
	input  wire logic [3*COEF_BITS-1:0] kernel_bottom_row,
	rkc3_res_if.source                  res
);
	localparam int AW    = COEF_BITS + 13;
	localparam int NW    = COEF_BITS + 4;
	localparam int PW    = COEF_BITS + CH_W + 1;
	localparam int CNT_W = $clog2(AW);

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_PREP, S_DIV, S_OUT} state_t;
	state_t state_q;

	rkc3_job_t               job_q;
	logic [1:0]              i_q, j_q;
	logic signed [AW-1:0]    acc_q [3];
	logic signed [NW-1:0]    norm_q;
	logic [AW-1:0]           dvd_q [3];
	logic [NW:0]             rem_q [3];
	logic                    neg_q [3];
	logic [NW-1:0]           dsr_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [3*COEF_BITS-1:0]  krow;
	logic signed [COEF_BITS-1:0] coef;
	logic [3:0]              widx;
	logic [RGB_W-1:0]        wpix;
	logic signed [PW-1:0]    prod [3];
	logic [NW:0]             rem_sh [3];
	logic [NW:0]             rem_sub [3];
	logic                    qbit [3];

	function automatic logic [CH_W-1:0] clamp_acc(input logic signed [AW-1:0] v);
		if (v < 0)
			return '0;
		else if (v > AW'(CH_MAX))
			return CH_W'(CH_MAX);
		else
			return v[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] clamp_quo(input logic neg, input logic [AW-1:0] q);
		if (neg)
			return '0;
		else if (q > AW'(CH_MAX))
			return CH_W'(CH_MAX);
		else
			return q[CH_W-1:0];
	endfunction

	always_comb begin
		case (i_q)
			2'd0:    krow = kernel_top_row;
			2'd1:    krow = kernel_middle_row;
			default: krow = kernel_bottom_row;
		endcase
		coef = krow[j_q*COEF_BITS +: COEF_BITS];
		widx = {1'b0, i_q, 1'b0} + {2'b00, i_q} + {2'b00, j_q};
		wpix = job_q.pixels[widx];
		for (int c = 0; c < 3; c++)
			prod[c] = PW'(coef) * PW'($signed({1'b0, wpix[(2-c)*CH_W +: CH_W]}));
	end

	// one restoring divide step per channel
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem_sh[c]  = {rem_q[c][NW-1:0], dvd_q[c][AW-1]};
			qbit[c]    = (rem_sh[c] >= {1'b0, dsr_q});
			rem_sub[c] = qbit[c] ? rem_sh[c] - {1'b0, dsr_q} : rem_sh[c];
		end
	end

	assign job_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res.valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_valid)
						state_q <= S_MAC;
				end
				S_MAC: begin
					if (i_q == 2'd2 && j_q == 2'd2)
						state_q <= S_PREP;
				end
				S_PREP: begin
					if (norm_q == '0) begin
						res.valid <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						res.valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (res.ready) begin
						res.valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				job_q  <= job;
				i_q    <= '0;
				j_q    <= '0;
				norm_q <= '0;
				for (int c = 0; c < 3; c++)
					acc_q[c] <= '0;
			end
			S_MAC: begin
				for (int c = 0; c < 3; c++)
					acc_q[c] <= acc_q[c] + AW'(prod[c]);
				norm_q <= norm_q + NW'(coef);
				if (j_q == 2'd2) begin
					j_q <= '0;
					i_q <= i_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
			S_PREP: begin
				dsr_q <= norm_q[NW-1] ? NW'(-norm_q) : NW'(norm_q);
				cnt_q <= CNT_W'(AW - 1);
				for (int c = 0; c < 3; c++) begin
					dvd_q[c] <= acc_q[c][AW-1] ? AW'(-acc_q[c]) : AW'(acc_q[c]);
					rem_q[c] <= '0;
					neg_q[c] <= acc_q[c][AW-1] ^ norm_q[NW-1];
				end
				if (norm_q == '0) begin
					res.out_red    <= clamp_acc(acc_q[0]);
					res.out_green  <= clamp_acc(acc_q[1]);
					res.out_blue   <= clamp_acc(acc_q[2]);
					res.out_column <= job_q.column;
					res.out_row    <= job_q.row;
					res.frame_last <= job_q.last;
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q - CNT_W'(1);
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= rem_sub[c];
					dvd_q[c] <= {dvd_q[c][AW-2:0], qbit[c]};
				end
				if (cnt_q == '0) begin
					res.out_red    <= clamp_quo(neg_q[0], {dvd_q[0][AW-2:0], qbit[0]});
					res.out_green  <= clamp_quo(neg_q[1], {dvd_q[1][AW-2:0], qbit[1]});
					res.out_blue   <= clamp_quo(neg_q[2], {dvd_q[2][AW-2:0], qbit[2]});
					res.out_column <= job_q.column;
					res.out_row    <= job_q.row;
					res.frame_last <= job_q.last;
				end
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

[design/rgb_kernel_convolution_3x3.sv]
// Top level of the 3x3 RGB convolution block with its register file.
`default_nettype none
// 3x3 convolution of an RGB pixel stream in raster order. The front end
// registers a pixel with both line stores read at its column, then shifts
// the window and writes the stores back before it takes the next pixel. When
// the window centre is an interior position with its select flag set, a job
// goes into a two-entry queue. The back end runs one job at a time: nine
// multiply-accumulate steps, one step per coefficient with a multiplier per
// channel, then a restoring divide by the coefficient sum at one quotient bit
// per cycle (skipped when the sum is 0), plus result handoff. The front end
// takes no pixel, selected or not, while the queue is full.
// Configure only while idle. Registers at byte address 4*i (8*i when
// 3*COEF_BITS exceeds 32): line_width, frame_height, kernel_top_row,
// kernel_middle_row, kernel_bottom_row. Reset kernel is identity.
module rgb_kernel_convolution_3x3 import rkc3_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	parameter int COEF_BITS = 8,
	localparam int KW     = 3 * COEF_BITS,
	localparam int DATA_W = (KW > 32) ? 64 : 32,
	localparam int SH     = (KW > 32) ? 3 : 2,
	localparam int ADDR_W = SH + REG_IDX_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	rkc3_pix_if.sink               pixels,
	rkc3_res_if.source             results
);
	logic [CFG_REG_W-1:0] line_width_q;
	logic [CFG_REG_W-1:0] frame_height_q;
	logic [KW-1:0]        kernel_top_q;
	logic [KW-1:0]        kernel_mid_q;
	logic [KW-1:0]        kernel_bot_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	rkc3_job_t front_job, back_job;
	logic      front_valid, q_not_full;
	logic      q_not_empty, back_ready;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:SH]);

	// register file; writes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= CFG_REG_W'(640);
			frame_height_q <= CFG_REG_W'(480);
			kernel_top_q   <= '0;
			kernel_mid_q   <= KW'(1) << COEF_BITS;
			kernel_bot_q   <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LINE_WIDTH:   line_width_q   <= pwdata[CFG_REG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_REG_W-1:0];
				REG_KERNEL_TOP:   kernel_top_q   <= pwdata[KW-1:0];
				REG_KERNEL_MID:   kernel_mid_q   <= pwdata[KW-1:0];
				REG_KERNEL_BOT:   kernel_bot_q   <= pwdata[KW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LINE_WIDTH:   prdata = DATA_W'(line_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			REG_KERNEL_TOP:   prdata = DATA_W'(kernel_top_q);
			REG_KERNEL_MID:   prdata = DATA_W'(kernel_mid_q);
			REG_KERNEL_BOT:   prdata = DATA_W'(kernel_bot_q);
			default:          prdata = '0;
		endcase
	end

	// front end: counters, line stores, window
	rkc3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pixels),
		.line_width   (line_width_q),
		.frame_height (frame_height_q),
		.job          (front_job),
		.job_valid    (front_valid),
		.job_ready    (q_not_full)
	);

	// decouples the pixel stream from the slow arithmetic
	rkc3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_job  (front_job),
		.not_full  (q_not_full),
		.pop       (back_ready),
		.pop_job   (back_job),
		.not_empty (q_not_empty)
	);

	// back end: MAC, divide, clamp, output register
	rkc3_back #(.COEF_BITS(COEF_BITS)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.job               (back_job),
		.job_valid         (q_not_empty),
		.job_ready         (back_ready),
		.kernel_top_row    (kernel_top_q),
		.kernel_middle_row (kernel_mid_q),
		.kernel_bottom_row (kernel_bot_q),
		.res               (results)
	);
endmodule
`default_nettype wire
